// ===== design/spo2_ratio_of_ratios_assert.svh =====
// Assertion macros for the SpO2 ratio-of-ratios block.
`ifndef SPO2_RATIO_OF_RATIOS_ASSERT_SVH
`define SPO2_RATIO_OF_RATIOS_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Checked outside reset only.
`define SPO2_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("spo2 assertion failed");
// Checked at every edge, reset included.
`define SPO2_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("spo2 assertion failed");
`else
`define SPO2_ASSERT(lbl, prop)
`define SPO2_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== design/spo2_pkg.sv =====
`timescale 1ns / 1ps

package spo2_pkg;

  localparam int WINDOW_SAMPLES = 16;
  localparam int SAMPLE_W       = 16;
  // Window length is a power of two: the mean is a right shift by CNT_W.
  localparam int CNT_W          = $clog2(WINDOW_SAMPLES);
  localparam int SUM_W          = SAMPLE_W + CNT_W;
  localparam int PROD_W         = SUM_W + SAMPLE_W;
  localparam int MUL_B_W        = SAMPLE_W;
  localparam int MUL_P_W        = PROD_W + MUL_B_W;
  localparam int DIV_Q_W        = 12;
  localparam int SCALED_W       = PROD_W + DIV_Q_W;
  localparam int DIV_CNT_W      = $clog2(DIV_Q_W + 1);
  localparam int SPO2_W         = 14;
  localparam int STEP_W         = DIV_Q_W + 1;

  localparam logic [MUL_B_W-1:0]  SPO2_SLOPE  = MUL_B_W'(2500);
  localparam logic [SPO2_W-1:0]   SPO2_BASE   = SPO2_W'(11000);
  localparam logic [SPO2_W-1:0]   SPO2_CAP    = SPO2_W'(10000);
  localparam logic [SAMPLE_W-1:0] LEVEL_RESET = SAMPLE_W'(5000);

  typedef enum logic [1:0] {
    ST_VALID     = 2'd0,
    ST_NO_FINGER = 2'd1,
    ST_INVALID   = 2'd2,
    ST_LOW_SAT   = 2'd3
  } status_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] ir_sample;
    logic [SAMPLE_W-1:0] red_sample;
  } sample_t;

  typedef struct packed {
    status_t           status;
    logic [SPO2_W-1:0] spo2_centi;
  } result_t;

  typedef struct packed {
    logic [SUM_W-1:0]    ir_sum;
    logic [SUM_W-1:0]    red_sum;
    logic [SAMPLE_W-1:0] ir_low;
    logic [SAMPLE_W-1:0] ir_high;
    logic [SAMPLE_W-1:0] red_low;
    logic [SAMPLE_W-1:0] red_high;
  } stats_t;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quot;
    logic               rem_nz;
  } div_res_t;

endpackage

// ===== design/spo2_accum.sv =====
`timescale 1ns / 1ps

module spo2_accum import spo2_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    beat,
  input  sample_t sample,
  input  logic    clear,
  output stats_t  stats,
  output logic    last
);

  logic [CNT_W-1:0] sample_count;

  assign last = (sample_count == CNT_W'(WINDOW_SAMPLES - 1));

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      sample_count   <= '0;
      stats.ir_sum   <= '0;
      stats.red_sum  <= '0;
      stats.ir_low   <= '1;
      stats.ir_high  <= '0;
      stats.red_low  <= '1;
      stats.red_high <= '0;
    end else if (beat) begin
      // hold the count at the last slot; the window end clears it
      if (!last) begin
        sample_count <= sample_count + CNT_W'(1);
      end
      stats.ir_sum  <= stats.ir_sum + SUM_W'(sample.ir_sample);
      stats.red_sum <= stats.red_sum + SUM_W'(sample.red_sample);
      if (sample.ir_sample < stats.ir_low) begin
        stats.ir_low <= sample.ir_sample;
      end
      if (sample.ir_sample > stats.ir_high) begin
        stats.ir_high <= sample.ir_sample;
      end
      if (sample.red_sample < stats.red_low) begin
        stats.red_low <= sample.red_sample;
      end
      if (sample.red_sample > stats.red_high) begin
        stats.red_high <= sample.red_sample;
      end
    end
  end

endmodule

// ===== design/spo2_mul.sv =====
`timescale 1ns / 1ps

module spo2_mul import spo2_pkg::*; (
  input  logic               clk,
  input  logic [PROD_W-1:0]  a,
  input  logic [MUL_B_W-1:0] b,
  output logic [MUL_P_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= MUL_P_W'(a) * MUL_P_W'(b);
  end

endmodule

// ===== design/spo2_div.sv =====
`timescale 1ns / 1ps

module spo2_div import spo2_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [SCALED_W-1:0] dividend,
  input  logic [PROD_W-1:0]   divisor,
  output div_res_t            res
);

  // Restoring division, one quotient bit a cycle. The quotient is known to
  // fit DIV_Q_W bits, so the top of the dividend starts below the divisor.
  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [PROD_W-1:0]    rem;
  logic [DIV_Q_W-1:0]   low;
  logic [DIV_Q_W-1:0]   quot;
  logic [PROD_W:0]      trial;
  logic                 ge;

  assign trial = {rem, low[DIV_Q_W-1]};
  assign ge    = (trial >= {1'b0, divisor});

  assign res.done   = busy && (cnt == '0);
  assign res.quot   = quot;
  assign res.rem_nz = (rem != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(DIV_Q_W);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= dividend[SCALED_W-1:DIV_Q_W];
      low  <= dividend[DIV_Q_W-1:0];
      quot <= '0;
    end else if (busy && (cnt != '0)) begin
      rem  <= ge ? PROD_W'(trial - {1'b0, divisor}) : trial[PROD_W-1:0];
      low  <= {low[DIV_Q_W-2:0], 1'b0};
      quot <= {quot[DIV_Q_W-2:0], ge};
    end
  end

endmodule

// ===== design/spo2_ratio_of_ratios.sv =====
// Window samples: one beat per cycle while collecting a window, but the last
// sample of a window waits while the previous result is still not accepted.
// A window's result is set by the no-finger or invalid checks, else by the
// low-saturation compare, else by three passes through the shared multiplier
// and a 12-step divider. No samples are taken while a window is evaluated.
// Reset (synchronous, active high) clears the window and sets the level to 5000.
`timescale 1ns / 1ps

`include "spo2_ratio_of_ratios_assert.svh"

module spo2_ratio_of_ratios import spo2_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_ready,
  input  sample_t             sample,
  output logic                result_valid,
  input  logic                result_ready,
  output result_t             result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [SAMPLE_W-1:0] cfg_data
);

  typedef enum logic [6:0] {
    S_ACC   = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_MULN  = 7'b0000100,
    S_MULD  = 7'b0001000,
    S_CMP   = 7'b0010000,
    S_SCL   = 7'b0100000,
    S_DIV   = 7'b1000000
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [SAMPLE_W-1:0] level;
  logic                beat;
  logic                acc_last;
  logic                write_out;
  logic                div_start;
  stats_t              stats;
  div_res_t            div;
  result_t             res_next;
  logic [PROD_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [MUL_P_W-1:0]  mul_p;
  logic [PROD_W-1:0]   num;
  logic [PROD_W-1:0]   den;
  logic [SAMPLE_W-1:0] ir_swing;
  logic [SAMPLE_W-1:0] red_swing;
  logic                no_finger;
  logic                flat;
  logic [STEP_W-1:0]   step;
  logic [SPO2_W-1:0]   spo2_raw;

  assign cfg_ready    = 1'b1;
  // refuse the window's last sample while the previous result still waits
  assign sample_ready = (state == S_ACC) && !(acc_last && result_valid);
  assign beat         = sample_valid && sample_ready;

  spo2_accum u_accum (
    .clk    (clk),
    .rst    (rst),
    .beat   (beat),
    .sample (sample),
    .clear  (write_out),
    .stats  (stats),
    .last   (acc_last)
  );

  spo2_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  spo2_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mul_p[SCALED_W-1:0]),
    .divisor  (den),
    .res      (div)
  );

  assign ir_swing  = stats.ir_high - stats.ir_low;
  assign red_swing = stats.red_high - stats.red_low;
  assign no_finger = ((stats.ir_sum >> CNT_W) < SUM_W'(level)) ||
                     ((stats.red_sum >> CNT_W) < SUM_W'(level));
  assign flat      = (ir_swing == '0) || (stats.ir_sum == '0) || (stats.red_sum == '0);

  // ceil(2500 * R): round up on a non-zero remainder
  assign step     = STEP_W'(div.quot) + STEP_W'(div.rem_nz);
  assign spo2_raw = SPO2_BASE - SPO2_W'(step);

  always_comb begin
    mul_a = PROD_W'(stats.ir_sum);
    mul_b = red_swing;
    unique case (state)
      S_MULD: begin
        mul_a = PROD_W'(stats.red_sum);
        mul_b = ir_swing;
      end
      S_CMP: begin
        mul_a = num;
        mul_b = SPO2_SLOPE;
      end
      default: begin
        mul_a = PROD_W'(stats.ir_sum);
        mul_b = red_swing;
      end
    endcase
  end

  always_comb begin
    state_next          = state;
    write_out           = 1'b0;
    div_start           = 1'b0;
    res_next.status     = ST_VALID;
    res_next.spo2_centi = '0;
    unique case (state)
      S_ACC: begin
        if (beat && acc_last) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (no_finger) begin
          write_out       = 1'b1;
          res_next.status = ST_NO_FINGER;
          state_next      = S_ACC;
        end else if (flat) begin
          write_out       = 1'b1;
          res_next.status = ST_INVALID;
          state_next      = S_ACC;
        end else begin
          state_next = S_MULN;
        end
      end
      S_MULN: begin
        state_next = S_MULD;
      end
      S_MULD: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        // product register holds the denominator here
        if (num > mul_p[PROD_W-1:0]) begin
          write_out       = 1'b1;
          res_next.status = ST_LOW_SAT;
          state_next      = S_ACC;
        end else begin
          state_next = S_SCL;
        end
      end
      S_SCL: begin
        div_start  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div.done) begin
          write_out           = 1'b1;
          res_next.spo2_centi = (spo2_raw > SPO2_CAP) ? SPO2_CAP : spo2_raw;
          state_next          = S_ACC;
        end
      end
      default: begin
        state_next = S_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_ACC;
      result_valid <= 1'b0;
      level        <= LEVEL_RESET;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        level <= cfg_data;
      end
      if (write_out) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (write_out) begin
      result <= res_next;
    end
    if (state == S_MULD) begin
      num <= mul_p[PROD_W-1:0];
    end
    if (state == S_CMP) begin
      den <= mul_p[PROD_W-1:0];
    end
  end

  `SPO2_ASSERT(a_zero_unless_valid, result_valid && (result.status != ST_VALID) |-> result.spo2_centi == '0)
  `SPO2_ASSERT(a_spo2_range, result_valid && (result.status == ST_VALID) |-> (result.spo2_centi >= SPO2_W'(8500)) && (result.spo2_centi <= SPO2_CAP))
  `SPO2_ASSERT(a_last_stalls, beat && acc_last |=> !sample_ready)
  `SPO2_ASSERT(a_div_done_in_div, div.done |-> state == S_DIV)
  `SPO2_ASSERT_ALWAYS(a_reset_idle, $past(rst) |-> !result_valid && (state == S_ACC))

endmodule

// ===== test/spo2_ratio_of_ratios_test.sv =====
`timescale 1ns / 1ps

module spo2_ratio_of_ratios_test;
  import spo2_pkg::*;

  localparam int SLOPE_CENTI = 2500;
  localparam int BASE_CENTI  = 11000;
  localparam int CAP_CENTI   = 10000;
  localparam logic [SAMPLE_W-1:0] LEVEL_AFTER_RESET = SAMPLE_W'(5000);
  localparam logic [SAMPLE_W-1:0] FULL_SCALE        = '1;
  // settle time that covers the longest evaluation after the last sample of a window
  localparam int SETTLE_CYCLES = 30;
  localparam int SHAPE_COUNT   = 10;

  typedef enum int {
    SH_EXTREMES,
    SH_FULL,
    SH_PULSE,
    SH_MATCHED,
    SH_RED_FLAT,
    SH_IR_FLAT,
    SH_DARK,
    SH_ZERO_RED,
    SH_DARKEST,
    SH_NOISE
  } window_shape_t;

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                sample_valid = 1'b0;
  logic                sample_ready;
  sample_t             sample       = '0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  result_t             result;
  logic                cfg_valid    = 1'b0;
  logic                cfg_ready;
  logic [SAMPLE_W-1:0] cfg_data     = '0;

  // window statistics as the block should hold them
  logic [SUM_W-1:0]    ir_total     = '0;
  logic [SUM_W-1:0]    red_total    = '0;
  logic [SAMPLE_W-1:0] ir_floor     = '1;
  logic [SAMPLE_W-1:0] ir_peak      = '0;
  logic [SAMPLE_W-1:0] red_floor    = '1;
  logic [SAMPLE_W-1:0] red_peak     = '0;
  int                  samples_in_window = 0;
  logic [SAMPLE_W-1:0] finger_level = LEVEL_AFTER_RESET;

  result_t expected_readings[$];
  sample_t pending_samples[$];
  sample_t window_rest[$];
  sample_t shaped_window[WINDOW_SAMPLES];

  int samples_loaded    = 0;
  int samples_taken     = 0;
  int sender_idle_pct   = 0;
  int receiver_idle_pct = 0;
  int failures          = 0;
  int readings_checked  = 0;
  int status_seen[4]    = '{default: 0};

  spo2_ratio_of_ratios uut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void accumulate_sample(sample_t s);
    logic [SAMPLE_W-1:0] ir_swing;
    logic [SAMPLE_W-1:0] red_swing;
    logic [63:0]         num;
    logic [63:0]         den;
    logic [63:0]         scaled;
    logic [63:0]         step;
    logic [63:0]         centi;
    result_t             r;
    ir_total  += SUM_W'(s.ir_sample);
    red_total += SUM_W'(s.red_sample);
    if (s.ir_sample < ir_floor) ir_floor = s.ir_sample;
    if (s.ir_sample > ir_peak) ir_peak = s.ir_sample;
    if (s.red_sample < red_floor) red_floor = s.red_sample;
    if (s.red_sample > red_peak) red_peak = s.red_sample;
    if (samples_in_window < WINDOW_SAMPLES - 1) begin
      samples_in_window++;
      return;
    end
    ir_swing     = ir_peak - ir_floor;
    red_swing    = red_peak - red_floor;
    r.status     = ST_VALID;
    r.spo2_centi = '0;
    if (ir_total / WINDOW_SAMPLES < finger_level ||
        red_total / WINDOW_SAMPLES < finger_level) begin
      r.status = ST_NO_FINGER;
    end else if (ir_swing == 0 || ir_total == 0 || red_total == 0) begin
      r.status = ST_INVALID;
    end else begin
      num = 64'(red_swing) * 64'(ir_total);
      den = 64'(ir_swing) * 64'(red_total);
      if (num > den) begin
        r.status = ST_LOW_SAT;
      end else begin
        // round the slope term up, so a ratio of exactly one gives 8500
        scaled = num * SLOPE_CENTI;
        step   = scaled / den;
        if (step * den != scaled) step++;
        centi = BASE_CENTI - step;
        r.spo2_centi = (centi > CAP_CENTI) ? SPO2_W'(CAP_CENTI) : SPO2_W'(centi);
      end
    end
    expected_readings.push_back(r);
    ir_total          = '0;
    red_total         = '0;
    ir_floor          = '1;
    ir_peak           = '0;
    red_floor         = '1;
    red_peak          = '0;
    samples_in_window = 0;
  endfunction

  task automatic shape_window(input window_shape_t shape);
    int                  ir_ac;
    int                  ir_dc;
    int                  red_ac;
    int                  red_dc;
    logic [SAMPLE_W-1:0] flat;
    logic [SAMPLE_W-1:0] ir;
    logic [SAMPLE_W-1:0] red;
    ir_ac  = $urandom_range(6000, 1);
    ir_dc  = $urandom_range(65535 - ir_ac, ir_ac);
    red_ac = $urandom_range(6000, 1);
    red_dc = $urandom_range(65535 - red_ac, red_ac);
    flat   = SAMPLE_W'($urandom_range(65535, 5000));
    for (int i = 0; i < WINDOW_SAMPLES; i++) begin
      ir  = SAMPLE_W'(ir_dc - ir_ac + int'($urandom_range(2 * ir_ac, 0)));
      red = SAMPLE_W'(red_dc - red_ac + int'($urandom_range(2 * red_ac, 0)));
      case (shape)
        SH_EXTREMES: begin
          ir  = i[0] ? FULL_SCALE : '0;
          red = i[1] ? FULL_SCALE : '0;
        end
        SH_FULL: begin
          ir  = FULL_SCALE;
          red = FULL_SCALE;
        end
        SH_PULSE: ;
        SH_MATCHED: red = ir;
        SH_RED_FLAT: red = flat;
        SH_IR_FLAT: ir = flat;
        SH_DARK: ir = SAMPLE_W'($urandom_range(4999, 0));
        SH_ZERO_RED: red = '0;
        SH_DARKEST: begin
          ir  = '0;
          red = '0;
        end
        default: begin
          ir  = SAMPLE_W'($urandom);
          red = SAMPLE_W'($urandom);
        end
      endcase
      shaped_window[i] = '{ir_sample: ir, red_sample: red};
    end
  endtask

  // Queue whole windows, then the first samples of one more; the remainder
  // of that window is held back for the next call.
  task automatic queue_windows(input int count, input int tail);
    int pick;
    while (window_rest.size() > 0) pending_samples.push_back(window_rest.pop_front());
    for (int w = 0; w < count + (tail > 0); w++) begin
      if (w < SHAPE_COUNT) begin
        pick = w;
      end else begin
        pick = $urandom_range(99);
        if (pick < 45) pick = SH_PULSE;
        else if (pick < 60) pick = SH_NOISE;
        else if (pick < 70) pick = SH_MATCHED;
        else pick = $urandom_range(SHAPE_COUNT - 1, 0);
      end
      shape_window(window_shape_t'(pick));
      for (int i = 0; i < WINDOW_SAMPLES; i++)
        if (w < count || i < tail) pending_samples.push_back(shaped_window[i]);
        else window_rest.push_back(shaped_window[i]);
    end
  endtask

  task automatic wait_idle();
    while (pending_samples.size() > 0 || samples_loaded != samples_taken ||
           expected_readings.size() > 0)
      @(posedge clk);
    // a part window produces nothing, yet an evaluation may still be running
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_level(input logic [SAMPLE_W-1:0] level);
    wait_idle();
    @(negedge clk);
    cfg_data  <= level;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    finger_level = level;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // advance to the next sample pair once the one on the bus has been taken
  always @(negedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (samples_loaded == samples_taken) begin
      if (pending_samples.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        sample       <= pending_samples.pop_front();
        sample_valid <= 1'b1;
        samples_loaded++;
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    result_ready <= !rst && ($urandom_range(99) >= receiver_idle_pct);
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (sample_valid && sample_ready) begin
        samples_taken++;
        accumulate_sample(sample);
      end
      if (result_valid && result_ready) begin
        readings_checked++;
        status_seen[result.status]++;
        if (expected_readings.size() == 0) begin
          failures++;
          $display("%0t: result beat with none expected: status %0d spo2 %0d",
                   $time, result.status, result.spo2_centi);
        end else begin
          want = expected_readings.pop_front();
          if (result.status !== want.status) begin
            failures++;
            $display("%0t: status expected %0d, got %0d",
                     $time, want.status, result.status);
          end
          if (result.spo2_centi !== want.spo2_centi) begin
            failures++;
            $display("%0t: spo2_centi expected %0d, got %0d",
                     $time, want.spo2_centi, result.spo2_centi);
          end
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    sender_idle_pct   = 16;
    receiver_idle_pct = 53;
    queue_windows(12, 5);
    // lands part way through a window
    write_level('0);

    sender_idle_pct   = 53;
    receiver_idle_pct = 16;
    queue_windows(11, 0);
    write_level(FULL_SCALE);

    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    queue_windows(3, 0);
    write_level(SAMPLE_W'($urandom_range(30000, 1000)));
    queue_windows(12, 0);

    wait_idle();
    $display("Fed %0d sample pairs, checked %0d windows over four finger levels:",
             samples_taken, readings_checked);
    $display("  %0d valid, %0d no finger, %0d invalid, %0d low saturation",
             status_seen[ST_VALID], status_seen[ST_NO_FINGER],
             status_seen[ST_INVALID], status_seen[ST_LOW_SAT]);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("%0t: timed out with %0d results outstanding", $time, expected_readings.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
